// ----- design/qvr_pkg.sv -----
// Shared constants and types for the quaternion vector rotation pipeline.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

    // Default fraction bits of the Q1.F quaternion parts.
    localparam int FRAC_BITS_DEF = 14;
    // Default width of one vector component.
    localparam int VEC_BITS_DEF = 24;
    // Fixed width of one quaternion part.
    localparam int QUAT_BITS = 16;
    // Width of a quaternion part after negation, which can reach +2^15.
    localparam int QNEG_BITS = QUAT_BITS + 1;
    // Low slice of the first product that is multiplied separately.
    localparam int SPLIT_BITS = 16;
    // Number of register stages from input transfer to output register.
    localparam int PIPE_DEPTH = 5;

    // One quaternion part and one negated or extended quaternion part.
    typedef logic signed [QUAT_BITS-1:0] t_quat;
    typedef logic signed [QNEG_BITS-1:0] t_qneg;

endpackage : qvr_pkg

`default_nettype wire

// ----- design/qvr_if.sv -----
// Valid/ready channel interfaces for the input vector and the rotated result.
// Depends on qvr_pkg for the quaternion type and the default vector width.
`timescale 1ns / 1ps
`default_nettype none

interface qvr_in_if import qvr_pkg::*; #(
    parameter int VEC_BITS = VEC_BITS_DEF
) ();
    logic                       valid;
    logic                       ready;
    logic signed [VEC_BITS-1:0] vec_x;
    logic signed [VEC_BITS-1:0] vec_y;
    logic signed [VEC_BITS-1:0] vec_z;
    t_quat                      quat_w;
    t_quat                      quat_x;
    t_quat                      quat_y;
    t_quat                      quat_z;

    modport source (
        output valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
        input  ready
    );
    modport sink (
        input  valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface : qvr_in_if

interface qvr_out_if import qvr_pkg::*; #(
    parameter int VEC_BITS = VEC_BITS_DEF
) ();
    logic                       valid;
    logic                       ready;
    logic signed [VEC_BITS-1:0] rot_x;
    logic signed [VEC_BITS-1:0] rot_y;
    logic signed [VEC_BITS-1:0] rot_z;
    logic                       saturated;

    modport source (
        output valid, rot_x, rot_y, rot_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, rot_x, rot_y, rot_z, saturated,
        output ready
    );
endinterface : qvr_out_if

`default_nettype wire

// ----- design/qvr_fwd_prod.sv -----
// First Hamilton product p = q * (0, v), two register stages:
// twelve partial products, then the four three-term sums. Uses qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qvr_fwd_prod import qvr_pkg::*; #(
    parameter int VEC_BITS = VEC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [VEC_BITS-1:0]            i_vec [3],
    input  wire t_quat                                 i_quat [4],
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [VEC_BITS+QUAT_BITS+1:0]       o_p [4],
    output t_quat                                      o_quat [4]
);

    localparam int PW1 = VEC_BITS + QUAT_BITS;
    localparam int PW  = VEC_BITS + QUAT_BITS + 2;

    logic                  r_vld_a;
    logic                  r_vld_b;
    logic                  en_a;
    logic                  en_b;
    logic signed [PW1-1:0] n_m [4][3];
    logic signed [PW1-1:0] r_m [4][3];
    t_quat                 r_quat_a [4];
    t_quat                 r_quat_b [4];
    logic signed [PW-1:0]  n_p [4];
    logic signed [PW-1:0]  r_p [4];

    // A stage advances when it is empty or the next one takes its item.
    assign en_b    = !r_vld_b || i_ready;
    assign en_a    = !r_vld_a || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vld_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (en_a) begin
                r_vld_a <= i_valid;
            end
            if (en_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    // Outer product of the quaternion parts (w, x, y, z) and the vector (x, y, z).
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_m[i][j] = PW1'(i_quat[i]) * PW1'(i_vec[j]);
            end
        end
    end

    // Scalar and vector parts of q * (0, v).
    always_comb begin
        n_p[0] = -(PW'(r_m[1][0]) + PW'(r_m[2][1]) + PW'(r_m[3][2]));
        n_p[1] = PW'(r_m[0][0]) + PW'(r_m[2][2]) - PW'(r_m[3][1]);
        n_p[2] = PW'(r_m[0][1]) - PW'(r_m[1][2]) + PW'(r_m[3][0]);
        n_p[3] = PW'(r_m[0][2]) + PW'(r_m[1][1]) - PW'(r_m[2][0]);
    end

    // Payload registers; the quaternion travels along for the second product.
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_m      <= n_m;
            r_quat_a <= i_quat;
        end
        if (en_b) begin
            r_p      <= n_p;
            r_quat_b <= r_quat_a;
        end
    end

    assign o_p    = r_p;
    assign o_quat = r_quat_b;

endmodule : qvr_fwd_prod

`default_nettype wire

// ----- design/qvr_conj_prod.sv -----
// Vector part of p * conj(q), two register stages: split partial products,
// then the four-term sums of high and low halves. Uses qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qvr_conj_prod import qvr_pkg::*; #(
    parameter int VEC_BITS = VEC_BITS_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_valid,
    output logic                                           o_ready,
    input  wire logic signed [VEC_BITS+QUAT_BITS+1:0]      i_p [4],
    input  wire t_quat                                     i_quat [4],
    output logic                                           o_valid,
    input  wire logic                                      i_ready,
    output logic signed [VEC_BITS+QUAT_BITS+3:0]           o_hs [3],
    output logic signed [SPLIT_BITS+QNEG_BITS+2:0]         o_ls [3]
);

    localparam int PW  = VEC_BITS + QUAT_BITS + 2;
    localparam int HW  = PW - SPLIT_BITS;
    localparam int LW  = SPLIT_BITS + 1;
    localparam int HPW = HW + QNEG_BITS;
    localparam int LPW = LW + QNEG_BITS;
    // Each p stays within three products of the first stage, so every high
    // partial product is well inside HPW bits and one extra bit holds the sum.
    localparam int HSW = HPW + 1;
    localparam int LSW = LPW + 2;

    logic                  r_vld_c;
    logic                  r_vld_d;
    logic                  en_c;
    logic                  en_d;
    t_qneg                 qe [4];
    t_qneg                 coef [3][4];
    logic signed [HW-1:0]  p_hi [4];
    logic signed [LW-1:0]  p_lo [4];
    logic signed [HPW-1:0] n_hp [3][4];
    logic signed [LPW-1:0] n_lp [3][4];
    logic signed [HPW-1:0] r_hp [3][4];
    logic signed [LPW-1:0] r_lp [3][4];
    logic signed [HSW-1:0] n_hs [3];
    logic signed [LSW-1:0] n_ls [3];
    logic signed [HSW-1:0] r_hs [3];
    logic signed [LSW-1:0] r_ls [3];

    assign en_d    = !r_vld_d || i_ready;
    assign en_c    = !r_vld_c || en_d;
    assign o_ready = en_c;
    assign o_valid = r_vld_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (en_c) begin
                r_vld_c <= i_valid;
            end
            if (en_d) begin
                r_vld_d <= r_vld_c;
            end
        end
    end

    // Coefficients of p * conj(q); q parts widened so that -(-2^15) fits.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qe[i] = QNEG_BITS'(i_quat[i]);
        end
        coef[0][0] = -qe[1]; coef[0][1] =  qe[0]; coef[0][2] = -qe[3]; coef[0][3] =  qe[2];
        coef[1][0] = -qe[2]; coef[1][1] =  qe[3]; coef[1][2] =  qe[0]; coef[1][3] = -qe[1];
        coef[2][0] = -qe[3]; coef[2][1] = -qe[2]; coef[2][2] =  qe[1]; coef[2][3] =  qe[0];
    end

    // Each p is split into a signed high part and an unsigned low slice,
    // which keeps the multipliers narrow.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            p_hi[k] = i_p[k][PW-1:SPLIT_BITS];
            p_lo[k] = {1'b0, i_p[k][SPLIT_BITS-1:0]};
        end
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 4; k++) begin
                n_hp[c][k] = HPW'(p_hi[k]) * HPW'(coef[c][k]);
                n_lp[c][k] = LPW'(p_lo[k]) * LPW'(coef[c][k]);
            end
        end
    end

    // Four-term sums, kept apart until the rounding stage.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_hs[c] = HSW'(r_hp[c][0]) + HSW'(r_hp[c][1])
                    + HSW'(r_hp[c][2]) + HSW'(r_hp[c][3]);
            n_ls[c] = LSW'(r_lp[c][0]) + LSW'(r_lp[c][1])
                    + LSW'(r_lp[c][2]) + LSW'(r_lp[c][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_hp <= n_hp;
            r_lp <= n_lp;
        end
        if (en_d) begin
            r_hs <= n_hs;
            r_ls <= n_ls;
        end
    end

    assign o_hs = r_hs;
    assign o_ls = r_ls;

endmodule : qvr_conj_prod

`default_nettype wire

// ----- design/qvr_round_sat.sv -----
// Output stage: joins high and low sums, rounds half up by 2*FRAC_BITS,
// saturates to the vector width and holds the result. Uses qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qvr_round_sat import qvr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int VEC_BITS  = VEC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [VEC_BITS+QUAT_BITS+3:0]  i_hs [3],
    input  wire logic signed [SPLIT_BITS+QNEG_BITS+2:0] i_ls [3],
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [VEC_BITS-1:0]                 o_rot [3],
    output logic                                       o_sat
);

    localparam int HSW = VEC_BITS + QUAT_BITS + 4;
    localparam int SW  = HSW + SPLIT_BITS + 1;

    localparam logic signed [SW-1:0] C_HALF = SW'(1) <<< (2 * FRAC_BITS - 1);
    localparam logic signed [SW-1:0] C_VMAX = (SW'(1) <<< (VEC_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] C_VMIN = -C_VMAX - SW'(1);

    logic                       r_vld;
    logic                       en;
    logic signed [SW-1:0]       sum [3];
    logic signed [SW-1:0]       rnd [3];
    logic                [2:0]  clip;
    logic signed [VEC_BITS-1:0] n_rot [3];
    logic signed [VEC_BITS-1:0] r_rot [3];
    logic                       r_sat;

    assign en      = !r_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_valid;
        end
    end

    // Full product, plus half an output step, floored by 2*FRAC_BITS.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = (SW'(i_hs[c]) <<< SPLIT_BITS) + SW'(i_ls[c]) + C_HALF;
            rnd[c] = sum[c] >>> (2 * FRAC_BITS);
            if (rnd[c] > C_VMAX) begin
                n_rot[c] = C_VMAX[VEC_BITS-1:0];
                clip[c]  = 1'b1;
            end else if (rnd[c] < C_VMIN) begin
                n_rot[c] = C_VMIN[VEC_BITS-1:0];
                clip[c]  = 1'b1;
            end else begin
                n_rot[c] = rnd[c][VEC_BITS-1:0];
                clip[c]  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot <= n_rot;
            r_sat <= |clip;
        end
    end

    assign o_rot = r_rot;
    assign o_sat = r_sat;

endmodule : qvr_round_sat

`default_nettype wire

// ----- design/quaternion_vector_rotate.sv -----
// Quaternion vector rotation v' = q * (0, v) * conj(q), five-stage pipeline.
// Depends on qvr_pkg, qvr_if, qvr_fwd_prod, qvr_conj_prod and qvr_round_sat.
//
// Usage:
//   i_vec is a valid/ready sink carrying a signed vector (vec_x, vec_y, vec_z)
//   and a Q1.FRAC_BITS quaternion (quat_w..quat_z). o_rot is a valid/ready
//   source carrying the rotated vector, rounded half up and clipped to
//   VEC_BITS, with saturated set when any component was clipped.
//   The quaternion is not normalized. An item passes two stages for
//   q * (0, v), two for the product with conj(q) and one output register
//   from the input transfer to o_rot.valid. Throughput is one item per cycle
//   while o_rot.ready is high; up to five items are in flight, one per stage.
//   When the receiver holds ready low, the output register keeps its result
//   and stages behind it keep filling until every stage holds an item; only
//   then does i_vec.ready fall. Nothing is dropped or duplicated.
//   Reset clears all stage valid bits, so no result appears until new input.
//   The block keeps no state between items.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotate import qvr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int VEC_BITS  = VEC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qvr_in_if.sink     i_vec,
    qvr_out_if.source  o_rot
);

    localparam int PW  = VEC_BITS + QUAT_BITS + 2;
    localparam int HSW = VEC_BITS + QUAT_BITS + 4;
    localparam int LSW = SPLIT_BITS + QNEG_BITS + 3;
    localparam int CW  = $clog2(PIPE_DEPTH + 1);

    logic signed [VEC_BITS-1:0] vec [3];
    t_quat                      quat [4];
    logic                       fwd_valid;
    logic                       fwd_ready;
    logic signed [PW-1:0]       fwd_p [4];
    t_quat                      fwd_quat [4];
    logic                       conj_valid;
    logic                       conj_ready;
    logic signed [HSW-1:0]      conj_hs [3];
    logic signed [LSW-1:0]      conj_ls [3];
    logic signed [VEC_BITS-1:0] rot [3];
    logic                       sat;
    logic [CW-1:0]              r_in_flight;
    logic [CW-1:0]              n_in_flight;
    logic                       in_xfer;
    logic                       out_xfer;

    // Gather the channel fields into arrays.
    assign vec[0]  = i_vec.vec_x;
    assign vec[1]  = i_vec.vec_y;
    assign vec[2]  = i_vec.vec_z;
    assign quat[0] = i_vec.quat_w;
    assign quat[1] = i_vec.quat_x;
    assign quat[2] = i_vec.quat_y;
    assign quat[3] = i_vec.quat_z;

    qvr_fwd_prod #(
        .VEC_BITS (VEC_BITS)
    ) u_fwd_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vec.valid),
        .o_ready (i_vec.ready),
        .i_vec   (vec),
        .i_quat  (quat),
        .o_valid (fwd_valid),
        .i_ready (fwd_ready),
        .o_p     (fwd_p),
        .o_quat  (fwd_quat)
    );

    qvr_conj_prod #(
        .VEC_BITS (VEC_BITS)
    ) u_conj_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fwd_valid),
        .o_ready (fwd_ready),
        .i_p     (fwd_p),
        .i_quat  (fwd_quat),
        .o_valid (conj_valid),
        .i_ready (conj_ready),
        .o_hs    (conj_hs),
        .o_ls    (conj_ls)
    );

    qvr_round_sat #(
        .FRAC_BITS (FRAC_BITS),
        .VEC_BITS  (VEC_BITS)
    ) u_round_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (conj_valid),
        .o_ready (conj_ready),
        .i_hs    (conj_hs),
        .i_ls    (conj_ls),
        .o_valid (o_rot.valid),
        .i_ready (o_rot.ready),
        .o_rot   (rot),
        .o_sat   (sat)
    );

    assign o_rot.rot_x     = rot[0];
    assign o_rot.rot_y     = rot[1];
    assign o_rot.rot_z     = rot[2];
    assign o_rot.saturated = sat;

    // Count of items accepted but not yet delivered.
    assign in_xfer  = i_vec.valid && i_vec.ready;
    assign out_xfer = o_rot.valid && o_rot.ready;

    always_comb begin
        n_in_flight = r_in_flight;
        if (in_xfer && !out_xfer) begin
            n_in_flight = r_in_flight + CW'(1);
        end else if (out_xfer && !in_xfer) begin
            n_in_flight = r_in_flight - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
        end else begin
            r_in_flight <= n_in_flight;
        end
    end

    // The pipeline never holds more items than it has stages.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_flight <= CW'(PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    // A result is only offered for an item that was accepted.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rot.valid |-> (r_in_flight != '0))
        else $error("result offered with no item in flight");

    // A full pipeline with a stalled receiver must refuse new input.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_flight == CW'(PIPE_DEPTH) && !o_rot.ready) |-> !i_vec.ready)
        else $error("input accepted while pipeline is full and stalled");

endmodule : quaternion_vector_rotate

`default_nettype wire

// ----- bench/tb_quaternion_vector_rotate.sv -----
// Self-checking testbench for quaternion_vector_rotate over its valid/ready channels.
// Depends on qvr_pkg, the qvr_in_if/qvr_out_if interfaces and the design top level.
// An exact integer predictor in a small scoreboard checks every result in order.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate;
    import qvr_pkg::*;

    localparam int FRAC_BITS  = FRAC_BITS_DEF;
    localparam int VEC_BITS   = VEC_BITS_DEF;
    localparam int RAND_ITEMS = 1400;
    localparam int CALM_FIRST = 400;
    localparam int CALM_LAST  = 599;
    localparam int DRAIN_AT   = 700;
    // About four times the slowest legal run with the longest gaps everywhere.
    localparam longint TIMEOUT_NS = 64'd8_000_000;

    localparam logic signed [VEC_BITS-1:0] VEC_MAX = {1'b0, {(VEC_BITS-1){1'b1}}};
    localparam logic signed [VEC_BITS-1:0] VEC_MIN = {1'b1, {(VEC_BITS-1){1'b0}}};

    // One input item and one rotated result.
    typedef struct {
        logic signed [VEC_BITS-1:0] vec_x;
        logic signed [VEC_BITS-1:0] vec_y;
        logic signed [VEC_BITS-1:0] vec_z;
        t_quat                      quat_w;
        t_quat                      quat_x;
        t_quat                      quat_y;
        t_quat                      quat_z;
    } t_vec_item;

    typedef struct {
        logic signed [VEC_BITS-1:0] rot_x;
        logic signed [VEC_BITS-1:0] rot_y;
        logic signed [VEC_BITS-1:0] rot_z;
        logic                       saturated;
    } t_rot_result;

    // Predicts rotations of accepted vectors and checks results in order.
    class rotation_scoreboard;
        t_rot_result expected_rot[$];
        int unsigned errors;
        int unsigned results_checked;

        function new();
            errors = 0;
            results_checked = 0;
        endfunction

        function int pending();
            return expected_rot.size();
        endfunction

        // Round half up by 2*FRAC_BITS, then clip to the vector range.
        function logic signed [VEC_BITS-1:0] round_clip(longint acc, ref logic sat);
            longint r;
            longint vmax;
            longint vmin;
            vmax = (longint'(1) <<< (VEC_BITS - 1)) - 1;
            vmin = -vmax - 1;
            r = (acc + (longint'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
            if (r > vmax) begin
                r = vmax;
                sat = 1'b1;
            end
            if (r < vmin) begin
                r = vmin;
                sat = 1'b1;
            end
            return r[VEC_BITS-1:0];
        endfunction

        // Exact vector part of q * (0, v) * conj(q).
        function t_rot_result predict_rotation(t_vec_item it);
            t_rot_result res;
            longint vx, vy, vz, qw, qx, qy, qz;
            longint ps, px, py, pz;
            longint acc_x, acc_y, acc_z;
            logic sat;
            vx = it.vec_x;
            vy = it.vec_y;
            vz = it.vec_z;
            qw = it.quat_w;
            qx = it.quat_x;
            qy = it.quat_y;
            qz = it.quat_z;
            ps = -(qx * vx + qy * vy + qz * vz);
            px = qw * vx + qy * vz - qz * vy;
            py = qw * vy - qx * vz + qz * vx;
            pz = qw * vz + qx * vy - qy * vx;
            acc_x = -ps * qx + px * qw - py * qz + pz * qy;
            acc_y = -ps * qy + px * qz + py * qw - pz * qx;
            acc_z = -ps * qz - px * qy + py * qx + pz * qw;
            sat = 1'b0;
            res.rot_x = round_clip(acc_x, sat);
            res.rot_y = round_clip(acc_y, sat);
            res.rot_z = round_clip(acc_z, sat);
            res.saturated = sat;
            return res;
        endfunction

        function void note_input(t_vec_item it);
            expected_rot.push_back(predict_rotation(it));
        endfunction

        function void check_result(t_rot_result act);
            t_rot_result exp_r;
            if (expected_rot.size() == 0) begin
                $error("rotated result with no pending input");
                errors++;
                return;
            end
            exp_r = expected_rot.pop_front();
            results_checked++;
            if (act.rot_x !== exp_r.rot_x) begin
                $error("rot_x: expected %0d, actual %0d", exp_r.rot_x, act.rot_x);
                errors++;
            end
            if (act.rot_y !== exp_r.rot_y) begin
                $error("rot_y: expected %0d, actual %0d", exp_r.rot_y, act.rot_y);
                errors++;
            end
            if (act.rot_z !== exp_r.rot_z) begin
                $error("rot_z: expected %0d, actual %0d", exp_r.rot_z, act.rot_z);
                errors++;
            end
            if (act.saturated !== exp_r.saturated) begin
                $error("saturated: expected %0b, actual %0b", exp_r.saturated,
                       act.saturated);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    int unsigned items_sent;
    int unsigned directed_count;
    rotation_scoreboard sb;

    qvr_in_if  #(.VEC_BITS(VEC_BITS)) vec_if ();
    qvr_out_if #(.VEC_BITS(VEC_BITS)) rot_if ();

    quaternion_vector_rotate #(
        .FRAC_BITS(FRAC_BITS),
        .VEC_BITS (VEC_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vec  (vec_if),
        .o_rot  (rot_if)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the pipeline hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_vec_item mk_item(int vx, int vy, int vz,
                                          int qw, int qx, int qy, int qz);
        t_vec_item it;
        it.vec_x  = vx[VEC_BITS-1:0];
        it.vec_y  = vy[VEC_BITS-1:0];
        it.vec_z  = vz[VEC_BITS-1:0];
        it.quat_w = qw[QUAT_BITS-1:0];
        it.quat_x = qx[QUAT_BITS-1:0];
        it.quat_y = qy[QUAT_BITS-1:0];
        it.quat_z = qz[QUAT_BITS-1:0];
        return it;
    endfunction

    // Vector component: full range, small magnitude or an edge value.
    function automatic logic signed [VEC_BITS-1:0] rand_vec_component();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode < 6) return VEC_BITS'($urandom());
        if (mode < 8) return VEC_BITS'($signed($urandom_range(0, 2000)) - 1000);
        case ($urandom_range(0, 4))
            0: return VEC_MAX;
            1: return VEC_MIN;
            2: return '0;
            3: return '1;
            default: return VEC_BITS'(1);
        endcase
    endfunction

    // Present one item, hold it until the transfer, then note it.
    task automatic send_item(t_vec_item it);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            vec_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vec_if.valid  <= 1'b1;
        vec_if.vec_x  <= it.vec_x;
        vec_if.vec_y  <= it.vec_y;
        vec_if.vec_z  <= it.vec_z;
        vec_if.quat_w <= it.quat_w;
        vec_if.quat_x <= it.quat_x;
        vec_if.quat_y <= it.quat_y;
        vec_if.quat_z <= it.quat_z;
        do @(posedge i_clk); while (vec_if.ready !== 1'b1);
        sb.note_input(it);
        items_sent++;
    endtask

    // Receiver: check every transfer and stall ready at random.
    initial begin
        int unsigned stall_left;
        t_rot_result act;
        stall_left = 0;
        rot_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (rot_if.valid === 1'b1 && rot_if.ready === 1'b1) begin
                act.rot_x     = rot_if.rot_x;
                act.rot_y     = rot_if.rot_y;
                act.rot_z     = rot_if.rot_z;
                act.saturated = rot_if.saturated;
                sb.check_result(act);
            end
            if (stall_left > 0) begin
                rot_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rot_if.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) < 3) stall_left = pick_gap();
            end
            @(posedge i_clk);
        end
    end

    // Stimulus and end of run.
    initial begin
        t_vec_item it;
        real a, b, c, d, n, scale;
        int unsigned qmode;

        sb = new();
        idle_on = 1'b1;
        items_sent = 0;
        vec_if.valid  <= 1'b0;
        vec_if.vec_x  <= '0;
        vec_if.vec_y  <= '0;
        vec_if.vec_z  <= '0;
        vec_if.quat_w <= '0;
        vec_if.quat_x <= '0;
        vec_if.quat_y <= '0;
        vec_if.quat_z <= '0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identities, half turns, edges, rounding ties and clipping.
        send_item(mk_item(0, 0, 0, 16384, 0, 0, 0));
        send_item(mk_item(8388607, 8388607, 8388607, 16384, 0, 0, 0));
        send_item(mk_item(-8388608, -8388608, -8388608, 16384, 0, 0, 0));
        send_item(mk_item(-8388608, 8388607, -1, -16384, 0, 0, 0));
        send_item(mk_item(1, 2, 3, 0, 16384, 0, 0));
        send_item(mk_item(1, 2, 3, 0, 0, 16384, 0));
        send_item(mk_item(1, 2, 3, 0, 0, 0, 16384));
        send_item(mk_item(1000000, 0, 0, 11585, 0, 0, 11585));
        send_item(mk_item(0, -1000000, 0, 11585, -11585, 0, 0));
        // Ties at exactly one half round upward, also for negative values.
        send_item(mk_item(2, -2, 6, 8192, 0, 0, 0));
        send_item(mk_item(-6, 10, -10, 8192, 0, 0, 0));
        // Non-unit quaternions scale the vector past the range and clip.
        send_item(mk_item(8388607, -8388608, 5, 32767, 0, 0, 0));
        send_item(mk_item(-8388608, -8388608, -8388608, -32768, -32768, -32768, -32768));
        send_item(mk_item(8388607, -8388608, 8388607, 16384, 16384, 16384, 16384));
        send_item(mk_item(-1, -1, -1, 32767, 32767, 32767, 32767));
        send_item(mk_item(8388607, 8388607, 8388607, -32768, 32767, -32768, 32767));
        // Tiny and zero quaternions collapse the vector toward zero, then mixed rotations follow.
        send_item(mk_item(8388607, 8388607, 8388607, 1, 0, 0, 0));
        send_item(mk_item(8388607, -8388608, 8388607, 0, 0, 0, 0));
        send_item(mk_item(-8388608, 8388607, 0, 11585, 11585, 0, 0));
        send_item(mk_item(123456, -654321, 8388607, 8192, 8192, 8192, 8192));
        send_item(mk_item(4194304, 4194304, -4194304, 16384, -16384, 16384, -16384));
        directed_count = items_sent;

        // Random: mostly unit quaternions, some mildly scaled, some raw bit patterns.
        for (int i = 0; i < RAND_ITEMS; i++) begin
            idle_on = !(i >= CALM_FIRST && i <= CALM_LAST);
            it.vec_x = rand_vec_component();
            it.vec_y = rand_vec_component();
            it.vec_z = rand_vec_component();
            qmode = $urandom_range(0, 9);
            if (qmode < 2) begin
                it.quat_w = QUAT_BITS'($urandom());
                it.quat_x = QUAT_BITS'($urandom());
                it.quat_y = QUAT_BITS'($urandom());
                it.quat_z = QUAT_BITS'($urandom());
            end else begin
                a = $urandom_range(0, 65535) / 32767.5 - 1.0;
                b = $urandom_range(0, 65535) / 32767.5 - 1.0;
                c = $urandom_range(0, 65535) / 32767.5 - 1.0;
                d = $urandom_range(0, 65535) / 32767.5 - 1.0;
                n = $sqrt(a * a + b * b + c * c + d * d);
                if (n < 1.0e-3) begin
                    a = 1.0;
                    n = 1.0;
                end
                scale = (qmode < 3) ? 1.0 + $urandom_range(0, 500) / 1000.0 : 1.0;
                scale = scale * 16384.0 / n;
                it.quat_w = QUAT_BITS'($rtoi(a * scale + (a >= 0.0 ? 0.5 : -0.5)));
                it.quat_x = QUAT_BITS'($rtoi(b * scale + (b >= 0.0 ? 0.5 : -0.5)));
                it.quat_y = QUAT_BITS'($rtoi(c * scale + (c >= 0.0 ? 0.5 : -0.5)));
                it.quat_z = QUAT_BITS'($rtoi(d * scale + (d >= 0.0 ? 0.5 : -0.5)));
            end
            send_item(it);

            // Let the pipeline drain completely once before continuing.
            if (i == DRAIN_AT) begin
                vec_if.valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() > 0);
            end
        end
        idle_on = 1'b1;
        vec_if.valid <= 1'b0;

        // Wait for every expected result before the final report.
        do @(posedge i_clk); while (sb.pending() > 0);
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);

        $display("Covered %0d rotations (%0d directed, rest random) with gaps and stalls;",
                 items_sent, directed_count);
        $display("%0d results compared field by field.", sb.results_checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule : tb_quaternion_vector_rotate
